// ===== rtl/rtpal_pkg.sv =====
package rtpal_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned LEVEL_W = 3;

    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [LEVEL_W-1:0] t_level;

    // palette_mode codes
    localparam logic MODE_BASIC = 1'b0;
    localparam logic MODE_CUBE  = 1'b1;
    localparam logic MODE_RESET = MODE_CUBE;

    // Cube level boundaries: level steps up at each of these values
    localparam t_chan CUBE_L1 = 8'd48;
    localparam t_chan CUBE_L2 = 8'd95;
    localparam t_chan CUBE_L3 = 8'd135;
    localparam t_chan CUBE_L4 = 8'd175;
    localparam t_chan CUBE_L5 = 8'd215;

    localparam t_index CUBE_BASE = 8'd16;

    // Basic colors sit at 0 or 170; midpoint 85 goes to 0 (lower index wins a tie)
    localparam t_chan BASIC_MID = 8'd85;

    function automatic t_level cube_level(input t_chan v);
        t_level lvl;
        if (v < CUBE_L1) begin
            lvl = 3'd0;
        end else if (v < CUBE_L2) begin
            lvl = 3'd1;
        end else if (v < CUBE_L3) begin
            lvl = 3'd2;
        end else if (v < CUBE_L4) begin
            lvl = 3'd3;
        end else if (v < CUBE_L5) begin
            lvl = 3'd4;
        end else begin
            lvl = 3'd5;
        end
        return lvl;
    endfunction

endpackage

// ===== rtl/rtpal_rgb_if.sv =====
interface rtpal_rgb_if;
    logic                 valid;
    logic                 ready;
    rtpal_pkg::t_chan     red_level;
    rtpal_pkg::t_chan     green_level;
    rtpal_pkg::t_chan     blue_level;

    modport source (output valid, output red_level, output green_level, output blue_level,
                    input ready);
    modport sink   (input valid, input red_level, input green_level, input blue_level,
                    output ready);
endinterface

// ===== rtl/rtpal_idx_if.sv =====
interface rtpal_idx_if;
    logic                 valid;
    logic                 ready;
    rtpal_pkg::t_index    palette_index;

    modport source (output valid, output palette_index, input ready);
    modport sink   (input valid, input palette_index, output ready);
endinterface

// ===== rtl/rtpal_quant.sv =====
module rtpal_quant (
    input  logic              i_mode,
    input  rtpal_pkg::t_chan  i_red,
    input  rtpal_pkg::t_chan  i_green,
    input  rtpal_pkg::t_chan  i_blue,
    output rtpal_pkg::t_index o_index
);

    rtpal_pkg::t_level w_r6;
    rtpal_pkg::t_level w_g6;
    rtpal_pkg::t_level w_b6;
    rtpal_pkg::t_index w_cube;
    rtpal_pkg::t_index w_basic;

    assign w_r6 = rtpal_pkg::cube_level(i_red);
    assign w_g6 = rtpal_pkg::cube_level(i_green);
    assign w_b6 = rtpal_pkg::cube_level(i_blue);

    // 36*r + 6*g + b <= 215, so the sum stays within 8 bits
    assign w_cube = rtpal_pkg::CUBE_BASE
                  + (rtpal_pkg::t_index'(w_r6) * 8'd36)
                  + (rtpal_pkg::t_index'(w_g6) * 8'd6)
                  + rtpal_pkg::t_index'(w_b6);

    assign w_basic = {5'd0,
                      (i_blue  > rtpal_pkg::BASIC_MID),
                      (i_green > rtpal_pkg::BASIC_MID),
                      (i_red   > rtpal_pkg::BASIC_MID)};

    assign o_index = (i_mode == rtpal_pkg::MODE_CUBE) ? w_cube : w_basic;

endmodule

// ===== rtl/rgb_to_terminal_palette_unit.sv =====
// RGB to terminal palette index converter.
//
// Input channel i_pix carries one 8-bit red/green/blue triple per transfer;
// output channel o_idx carries one 8-bit palette index per input, in order.
// Both use valid/ready; a transfer happens when both are high at a clock edge.
// i_cfg_we/i_cfg_wdata write palette_mode (0: nearest of eight basic colors,
// index 0..7; 1: 6x6x6 color cube, index 16..231). Write it only while idle.
//
// A pixel taken on i_pix is captured in the input register; its index is then
// loaded into the result register and is valid on o_idx from then on.
// Throughput is one pixel per clock while o_idx.ready is high, set by the two-register path.
//
// Reset (synchronous, i_rst_n low) empties both registers and sets the cube
// mode. When the receiver holds o_idx.ready low, the result register holds its
// index; the input register takes one more pixel only if it is empty, after
// which i_pix.ready drops until the result register is freed.
module rgb_to_terminal_palette_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    rtpal_rgb_if.sink     i_pix,
    rtpal_idx_if.source   o_idx
);

    logic              r_mode;
    logic              r_in_vld;
    rtpal_pkg::t_chan  r_red;
    rtpal_pkg::t_chan  r_green;
    rtpal_pkg::t_chan  r_blue;
    logic              r_out_vld;
    rtpal_pkg::t_index r_out_idx;

    logic              w_in_rdy;
    logic              w_out_rdy;
    rtpal_pkg::t_index n_out_idx;

    assign w_out_rdy = !r_out_vld || o_idx.ready;
    assign w_in_rdy  = !r_in_vld  || w_out_rdy;

    assign i_pix.ready         = w_in_rdy;
    assign o_idx.valid         = r_out_vld;
    assign o_idx.palette_index = r_out_idx;

    rtpal_quant u_quant (
        .i_mode  (r_mode),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_index (n_out_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= rtpal_pkg::MODE_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_in_rdy) begin
                r_in_vld <= i_pix.valid;
            end
            if (w_out_rdy) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_rdy && i_pix.valid) begin
            r_red   <= i_pix.red_level;
            r_green <= i_pix.green_level;
            r_blue  <= i_pix.blue_level;
        end
        if (w_out_rdy && r_in_vld) begin
            r_out_idx <= n_out_idx;
        end
    end

endmodule
